>>> hw/rtl/bti_pkg.sv
package bti_pkg;

  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 1;

  // restoring divider: quotient fits in 33 bits, remainder starts below the divisor
  localparam int DIV_STEPS = 33;
  localparam int STEP_W    = 6;

  localparam int FALLBACK_UNITS = 10;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INTERP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLOOR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CEIL   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BELOW   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABOVE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK    = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] entry_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic [POS_W-1:0]         segment;
    logic [STATUS_W-1:0]      status;
  } out_word_t;

  typedef struct packed {
    logic               capture;
    logic               dispatch;
    logic               rd_en;
    logic [COUNT_W-1:0] rd_idx;
    logic               resolve;
    logic               mul;
    logic               div_init;
    logic               div_step;
    logic               lerp_done;
    logic               emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] last_idx;
    logic               go_scan;
    logic               need_div;
  } ctl_stat_t;

endpackage

>>> hw/rtl/bti_ctrl.sv
module bti_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output bti_pkg::ctl_cmd_t   cmd,
  input  bti_pkg::ctl_stat_t  stat
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_DRAIN    = 4'd3;
  localparam logic [3:0] S_RESOLVE  = 4'd4;
  localparam logic [3:0] S_MUL      = 4'd5;
  localparam logic [3:0] S_DIVINIT  = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_LERP     = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  logic [3:0]                      state_r, state_nxt;
  logic [bti_pkg::COUNT_W-1:0]     idx_r, idx_nxt;
  logic [bti_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic                            out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.rd_idx    = idx_r;

    // the waiting word leaves independently of the work in progress
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        idx_nxt      = '0;
        state_nxt    = stat.go_scan ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (idx_r == stat.last_idx) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = stat.need_div ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == bti_pkg::STEP_W'(bti_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_LERP;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_LERP: begin
        cmd.lerp_done = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/bti_datapath.sv
module bti_datapath #(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bti_pkg::in_word_t                 in_data,
  output bti_pkg::out_word_t                out_data,
  input  logic                              cfg_we,
  input  logic [bti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bti_pkg::DATA_W-1:0]        cfg_data,
  input  bti_pkg::ctl_cmd_t                 cmd,
  output bti_pkg::ctl_stat_t                stat
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CAP = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
  localparam logic signed [bti_pkg::DATA_W-1:0] FALLBACK_RST =
    bti_pkg::DATA_W'(bti_pkg::FALLBACK_UNITS * (1 << FRAC_BITS));

  localparam int DW = bti_pkg::DATA_W;
  localparam int CW = bti_pkg::COUNT_W;
  localparam int PW = bti_pkg::POS_W;

  // configuration
  logic [CW-1:0]        entry_count_r;
  logic signed [DW-1:0] fallback_r;
  logic [CW-1:0]        active_n;

  // item
  bti_pkg::in_word_t    item_r;
  logic [CW-1:0]        n_r;
  logic signed [DW-1:0] x;
  logic [CW-1:0]        last_idx;

  // table
  logic signed [DW-1:0] key_mem [TABLE_DEPTH];
  logic signed [DW-1:0] val_mem [TABLE_DEPTH];
  logic signed [DW-1:0] key_rd_r, val_rd_r;
  logic                 cmp_valid_r;
  logic [CW-1:0]        cmp_idx_r;
  logic                 load_ok;

  // scan record
  logic signed [DW-1:0] k0_r, v0_r, klast_r, vlast_r, prevk_r, prevv_r;
  logic                 ifound_r, ffound_r, cfound_r;
  logic [CW-1:0]        iidx_r, fidx_r, cidx_r;
  logic signed [DW-1:0] ik0_r, ik1_r, iv0_r, iv1_r, fval_r, cval_r;
  logic                 lt, le;

  // lerp
  logic [DW-1:0]        mag_r, t_r, dx_r;
  logic                 neg_r;
  logic [2*DW-1:0]      prod_r;
  logic [DW-1:0]        rem_r;
  logic [DW:0]          dvd_r;
  logic [DW-1:0]        quot_r;
  logic [DW:0]          trial;
  logic                 trial_ge;
  logic signed [DW:0]   dy;
  logic [DW:0]          mag_full;

  bti_pkg::out_word_t   res_r, res_nxt;
  bti_pkg::out_word_t   out_r;
  logic                 need_div;

  assign active_n = (entry_count_r > CW'(CAP)) ? CW'(CAP) : entry_count_r;
  assign x        = item_r.key;
  assign last_idx = n_r - 1'b1;
  assign load_ok  = ({1'b0, item_r.position} < n_r);

  assign stat.last_idx = last_idx;
  assign stat.go_scan  = (item_r.kind != bti_pkg::KIND_LOAD) && (n_r != '0);
  assign stat.need_div = need_div;
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      fallback_r    <= FALLBACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bti_pkg::CFG_ENTRY_COUNT: entry_count_r <= cfg_data[CW-1:0];
        bti_pkg::CFG_FALLBACK:    fallback_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
      n_r    <= active_n;
    end
  end

  // table memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.dispatch && item_r.kind == bti_pkg::KIND_LOAD && load_ok) begin
      key_mem[AW'(item_r.position)] <= item_r.key;
      val_mem[AW'(item_r.position)] <= item_r.entry_value;
    end
    if (cmd.rd_en) begin
      key_rd_r <= key_mem[AW'(cmd.rd_idx)];
      val_rd_r <= val_mem[AW'(cmd.rd_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_valid_r <= 1'b0;
    end else begin
      cmp_valid_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmd.rd_idx;
  end

  assign lt = (x < key_rd_r);
  assign le = (x <= key_rd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ifound_r <= 1'b0;
      ffound_r <= 1'b0;
      cfound_r <= 1'b0;
    end else if (cmd.capture) begin
      ifound_r <= 1'b0;
      ffound_r <= 1'b0;
      cfound_r <= 1'b0;
    end else if (cmp_valid_r) begin
      if (!ifound_r && cmp_idx_r != '0 && lt) begin
        ifound_r <= 1'b1;
      end
      if (!lt) begin
        ffound_r <= 1'b1;
      end
      if (!cfound_r && le) begin
        cfound_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_valid_r) begin
      prevk_r <= key_rd_r;
      prevv_r <= val_rd_r;
      if (cmp_idx_r == '0) begin
        k0_r <= key_rd_r;
        v0_r <= val_rd_r;
      end
      if (cmp_idx_r == last_idx) begin
        klast_r <= key_rd_r;
        vlast_r <= val_rd_r;
      end
      // first entry above the key brackets the interpolation segment
      if (!ifound_r && cmp_idx_r != '0 && lt) begin
        iidx_r <= cmp_idx_r - 1'b1;
        ik0_r  <= prevk_r;
        iv0_r  <= prevv_r;
        ik1_r  <= key_rd_r;
        iv1_r  <= val_rd_r;
      end
      // floor keeps the highest match
      if (!lt) begin
        fidx_r <= cmp_idx_r;
        fval_r <= val_rd_r;
      end
      if (!cfound_r && le) begin
        cidx_r <= cmp_idx_r;
        cval_r <= val_rd_r;
      end
    end
  end

  assign dy       = {iv1_r[DW-1], iv1_r} - {iv0_r[DW-1], iv0_r};
  assign mag_full = dy[DW] ? ((DW+1)'(0) - dy) : dy;

  always_comb begin
    res_nxt  = res_r;
    need_div = 1'b0;
    if (cmd.dispatch) begin
      if (item_r.kind == bti_pkg::KIND_LOAD) begin
        res_nxt.result  = '0;
        res_nxt.segment = item_r.position;
        res_nxt.status  = load_ok ? bti_pkg::ST_OK : bti_pkg::ST_IGNORED;
      end else begin
        res_nxt.result  = '0;
        res_nxt.segment = '0;
        res_nxt.status  = bti_pkg::ST_EMPTY;
      end
    end else if (cmd.lerp_done) begin
      res_nxt.result = neg_r ? (iv0_r - quot_r) : (iv0_r + quot_r);
    end else begin
      case (item_r.kind)
        bti_pkg::KIND_INTERP: begin
          if (x < k0_r) begin
            res_nxt.result  = '0;
            res_nxt.segment = '0;
            res_nxt.status  = bti_pkg::ST_BELOW;
          end else if (x >= klast_r) begin
            res_nxt.result  = vlast_r;
            res_nxt.segment = last_idx[PW-1:0];
            res_nxt.status  = (x > klast_r) ? bti_pkg::ST_ABOVE : bti_pkg::ST_OK;
          end else if (ifound_r) begin
            res_nxt.result  = iv0_r;
            res_nxt.segment = iidx_r[PW-1:0];
            res_nxt.status  = bti_pkg::ST_OK;
            need_div        = 1'b1;
          end else begin
            res_nxt.result  = vlast_r;
            res_nxt.segment = last_idx[PW-1:0];
            res_nxt.status  = bti_pkg::ST_OK;
          end
        end
        bti_pkg::KIND_FLOOR: begin
          if (x < k0_r) begin
            res_nxt.result  = fallback_r;
            res_nxt.segment = '0;
            res_nxt.status  = bti_pkg::ST_BELOW;
          end else if (ffound_r) begin
            res_nxt.result  = fval_r;
            res_nxt.segment = fidx_r[PW-1:0];
            res_nxt.status  = bti_pkg::ST_OK;
          end else begin
            res_nxt.result  = v0_r;
            res_nxt.segment = '0;
            res_nxt.status  = bti_pkg::ST_OK;
          end
        end
        bti_pkg::KIND_CEIL: begin
          if (cfound_r) begin
            res_nxt.result  = cval_r;
            res_nxt.segment = cidx_r[PW-1:0];
            res_nxt.status  = bti_pkg::ST_OK;
          end else begin
            res_nxt.result  = fallback_r;
            res_nxt.segment = last_idx[PW-1:0];
            res_nxt.status  = bti_pkg::ST_ABOVE;
          end
        end
        default: begin
          res_nxt.result  = '0;
          res_nxt.segment = '0;
          res_nxt.status  = bti_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dispatch || cmd.resolve || cmd.lerp_done) begin
      res_r <= res_nxt;
    end
    if (cmd.emit) begin
      out_r <= res_r;
    end
  end

  // lerp operands: key steps fit 32 bits unsigned inside the bracket
  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      neg_r <= dy[DW];
      mag_r <= mag_full[DW-1:0];
      t_r   <= DW'(x - ik0_r);
      dx_r  <= DW'(ik1_r - ik0_r);
    end
    if (cmd.mul) begin
      prod_r <= mag_r * t_r;
    end
  end

  assign trial    = {rem_r, dvd_r[DW]};
  assign trial_ge = (trial >= {1'b0, dx_r});

  // one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= {1'b0, prod_r[2*DW-1:DW+1]};
      dvd_r  <= prod_r[DW:0];
      quot_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= trial_ge ? DW'(trial - {1'b0, dx_r}) : trial[DW-1:0];
      dvd_r  <= {dvd_r[DW-1:0], 1'b0};
      quot_r <= {quot_r[DW-2:0], trial_ge};
    end
  end

endmodule

>>> hw/rtl/breakpoint_table_interpolator.sv
// Breakpoint table with linear, floor-step and ceiling-step lookup in Q15.16.
// Input channel (in_valid/in_stall/in_data) takes one word per item: a load
// writes one table entry, a query looks a key up. Every item gives exactly
// one result word on the output channel (out_valid/out_stall/out_data).
// A new item is taken only once the previous one has finished; its result
// then waits in the output register while the next item is taken in.
// Loads and queries on an empty table go from acceptance through dispatch
// straight to the output. Step lookups and interpolation at or outside the
// ends scan every active entry, one entry read a cycle from the table memory;
// interpolation inside the table then adds the multiply and the bit-serial
// divide.
// The next item can be taken in the same cycle that out_valid rises.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// index 0 is the entry count, index 1 the fallback value. The user must write
// it only while no item is in flight; the block itself does not enforce this.
// A stalled output holds its word; the block finishes the next item and waits
// for the output register to free before loading it.
// Synchronous reset clears control, the entry count and sets the fallback to
// ten; table contents are undefined until loaded.
module breakpoint_table_interpolator #(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bti_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bti_pkg::out_word_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bti_pkg::DATA_W-1:0]     cfg_data
);

  bti_pkg::ctl_cmd_t  cmd;
  bti_pkg::ctl_stat_t stat;

  assign cfg_ready = 1'b1;

  bti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  bti_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> dv/tb_breakpoint_table_interpolator.sv
module tb_breakpoint_table_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  localparam int FRAC_BITS   = 16;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int LONG_HOLD   = 600;
  localparam int NUM_PHASES  = 11;

  typedef enum {KEYS_SPREAD, KEYS_DUPS, KEYS_DENSE, KEYS_SHUFFLED, KEYS_EDGES} key_style_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  bti_pkg::in_word_t                 in_data = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  bti_pkg::out_word_t                out_data;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [bti_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [bti_pkg::DATA_W-1:0]        cfg_data = '0;

  // predictor state
  logic signed [bti_pkg::DATA_W-1:0] key_mem [TABLE_DEPTH];
  logic signed [bti_pkg::DATA_W-1:0] val_mem [TABLE_DEPTH];
  logic [bti_pkg::COUNT_W-1:0]       count_reg = '0;
  logic signed [bti_pkg::DATA_W-1:0] fallback_reg =
    bti_pkg::DATA_W'(bti_pkg::FALLBACK_UNITS << FRAC_BITS);

  // stimulus plan: what the table will hold once the queued loads land
  logic signed [bti_pkg::DATA_W-1:0] plan_key [TABLE_DEPTH];
  int                                plan_n = 0;

  bti_pkg::in_word_t  pending[$];
  bti_pkg::out_word_t answers_due[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  breakpoint_table_interpolator #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bti_pkg::out_word_t table_answer(input bti_pkg::in_word_t w);
    bti_pkg::out_word_t r;
    int                 n;
    longint             x, a, t, dx, dy;
    longint unsigned    mag, tu, du, q;
    bit                 hit;
    n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
    x = longint'($signed(w.key));
    r = '0;
    hit = 1'b0;
    if (w.kind == bti_pkg::KIND_LOAD) begin
      r.segment = w.position;
      if (w.position >= n) begin
        r.status = bti_pkg::ST_IGNORED;
      end else begin
        key_mem[w.position] = w.key;
        val_mem[w.position] = w.entry_value;
        r.status = bti_pkg::ST_OK;
      end
    end else if (n == 0) begin
      r.status = bti_pkg::ST_EMPTY;
    end else if (w.kind == bti_pkg::KIND_INTERP) begin
      if (x < key_mem[0]) begin
        r.status = bti_pkg::ST_BELOW;
      end else if (x >= key_mem[n-1]) begin
        r.result  = val_mem[n-1];
        r.segment = bti_pkg::POS_W'(n - 1);
        r.status  = (x > key_mem[n-1]) ? bti_pkg::ST_ABOVE : bti_pkg::ST_OK;
      end else begin
        r.result  = val_mem[n-1];
        r.segment = bti_pkg::POS_W'(n - 1);
        r.status  = bti_pkg::ST_OK;
        // first key above x closes the segment, so duplicates resolve upward
        for (int i = 1; i < n && !hit; i++) begin
          if (x < key_mem[i]) begin
            a   = longint'(val_mem[i-1]);
            dy  = longint'(val_mem[i]) - a;
            t   = x - longint'(key_mem[i-1]);
            dx  = longint'(key_mem[i]) - longint'(key_mem[i-1]);
            mag = (dy < 0) ? $unsigned(-dy) : $unsigned(dy);
            tu  = $unsigned(t);
            du  = $unsigned(dx);
            q   = (mag * tu) / du;
            r.result  = bti_pkg::DATA_W'((dy < 0) ? a - longint'(q) : a + longint'(q));
            r.segment = bti_pkg::POS_W'(i - 1);
            hit = 1'b1;
          end
        end
      end
    end else if (w.kind == bti_pkg::KIND_FLOOR) begin
      if (x < key_mem[0]) begin
        r.result = fallback_reg;
        r.status = bti_pkg::ST_BELOW;
      end else begin
        r.result = val_mem[0];
        for (int i = n - 1; i >= 0 && !hit; i--) begin
          if (x >= key_mem[i]) begin
            r.result  = val_mem[i];
            r.segment = bti_pkg::POS_W'(i);
            hit = 1'b1;
          end
        end
      end
    end else begin
      r.result  = fallback_reg;
      r.segment = bti_pkg::POS_W'(n - 1);
      r.status  = bti_pkg::ST_ABOVE;
      for (int i = 0; i < n && !hit; i++) begin
        if (x <= key_mem[i]) begin
          r.result  = val_mem[i];
          r.segment = bti_pkg::POS_W'(i);
          r.status  = bti_pkg::ST_OK;
          hit = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // driver: a word leaves the queue only when the previous one was taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        answers_due.push_back(table_answer(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, counted down in cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor and receiver back-pressure
  always @(posedge clk) begin
    bti_pkg::out_word_t exp_word;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected word: result %h segment %0d status %0d",
                     out_data.result, out_data.segment, out_data.status);
          end
        end else begin
          exp_word = answers_due.pop_front();
          if (out_data.result !== exp_word.result || out_data.segment !== exp_word.segment ||
              out_data.status !== exp_word.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"mismatch: expected result %h segment %0d status %0d, ",
                        "got result %h segment %0d status %0d"},
                       exp_word.result, exp_word.segment, exp_word.status,
                       out_data.result, out_data.segment, out_data.status);
            end
          end
        end
      end
      out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [bti_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bti_pkg::DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bti_pkg::CFG_ENTRY_COUNT) begin
      count_reg = data[bti_pkg::COUNT_W-1:0];
      plan_n = (data[bti_pkg::COUNT_W-1:0] > TABLE_DEPTH) ? TABLE_DEPTH :
               int'(data[bti_pkg::COUNT_W-1:0]);
    end else begin
      fallback_reg = data;
    end
  endtask

  task automatic queue_word(input logic [bti_pkg::KIND_W-1:0] kind,
                            input logic [bti_pkg::POS_W-1:0] pos,
                            input logic [bti_pkg::DATA_W-1:0] key,
                            input logic [bti_pkg::DATA_W-1:0] val);
    bti_pkg::in_word_t w;
    w.kind        = kind;
    w.position    = pos;
    w.key         = key;
    w.entry_value = val;
    pending.push_back(w);
    if (kind == bti_pkg::KIND_LOAD && pos < plan_n) begin
      plan_key[pos] = key;
    end
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || in_valid || answers_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly queries aimed at the planned keys, with rewrites and ignored loads mixed in
  task automatic queue_random_items(input int how_many);
    int                                done, i, i2, last;
    logic signed [bti_pkg::DATA_W-1:0] k;
    longint                            span;
    longint unsigned                   r;
    done = 0;
    while (done < how_many) begin
      i    = (plan_n > 0) ? $urandom_range(plan_n - 1) : 0;
      last = (plan_n > 0) ? plan_n - 1 : 0;
      case ($urandom_range(99)) inside
        [0:9]: begin
          if (plan_n > 0) begin
            k = ($urandom_range(3) == 0) ? $urandom() : plan_key[i];
            queue_word(bti_pkg::KIND_LOAD, bti_pkg::POS_W'(i), k, $urandom());
            done++;
          end
        end
        [10:15]: begin
          if (plan_n < TABLE_DEPTH) begin
            queue_word(bti_pkg::KIND_LOAD,
                       bti_pkg::POS_W'($urandom_range(TABLE_DEPTH - 1, plan_n)),
                       $urandom(), $urandom());
          end
        end
        default: begin
          case ($urandom_range(9))
            0: k = plan_key[i];
            1: k = plan_key[i] + 1;
            2: k = plan_key[i] - 1;
            3, 4: begin
              i2   = (i + 1 < plan_n) ? i + 1 : i;
              span = longint'(plan_key[i2]) - longint'(plan_key[i]);
              if (span > 0) begin
                r = {$urandom(), $urandom()};
                k = bti_pkg::DATA_W'(longint'(plan_key[i]) + longint'(r % span));
              end else begin
                k = $urandom();
              end
            end
            5: k = plan_key[0] - $urandom_range(1000) - 1;
            6: k = plan_key[last] + $urandom_range(1000) + 1;
            7: k = 32'sh8000_0000;
            8: k = 32'sh7fff_ffff;
            default: k = $urandom();
          endcase
          queue_word(bti_pkg::KIND_W'($urandom_range(3, 1)),
                     bti_pkg::POS_W'($urandom_range(63)), k, $urandom());
          done++;
        end
      endcase
    end
  endtask

  initial begin
    int                         phase_count [NUM_PHASES];
    int                         ks[$];
    int                         pos_q[$];
    int                         base, p;
    key_style_t                 style;
    logic [bti_pkg::DATA_W-1:0] fb, v;

    phase_count = '{1, 2, 3, 64, 5, 8, 127, 16, 4, 6, 0};
    foreach (plan_key[i]) plan_key[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table straight out of reset, fallback untouched
    queue_word(bti_pkg::KIND_INTERP, 0, 32'sh0000_0000, 0);
    queue_word(bti_pkg::KIND_FLOOR, 63, 32'sh7fff_ffff, 32'hffff_ffff);
    queue_word(bti_pkg::KIND_CEIL, 0, 32'sh8000_0000, 0);
    queue_word(bti_pkg::KIND_LOAD, 0, 32'h1234_5678, 32'h0000_0001);
    queue_word(bti_pkg::KIND_LOAD, 63, 32'hffff_ffff, 32'hffff_ffff);
    wait_drained();

    // four entries with a repeated key in the middle
    write_reg(bti_pkg::CFG_ENTRY_COUNT, 32'd4);
    write_reg(bti_pkg::CFG_FALLBACK, 32'h8000_0000);
    queue_word(bti_pkg::KIND_LOAD, 0, 32'hffff_0000, 32'd100);
    queue_word(bti_pkg::KIND_LOAD, 1, 32'h0000_0000, 32'hffff_fff9);
    queue_word(bti_pkg::KIND_LOAD, 2, 32'h0000_0000, 32'd50);
    queue_word(bti_pkg::KIND_LOAD, 3, 32'h0002_0000, 32'h7fff_ffff);
    queue_word(bti_pkg::KIND_LOAD, 4, 32'h0003_0000, 32'd1);
    queue_word(bti_pkg::KIND_LOAD, 63, 32'h0004_0000, 32'd2);
    queue_word(bti_pkg::KIND_INTERP, 0, 32'h8000_0000, 0);
    queue_word(bti_pkg::KIND_INTERP, 0, 32'hffff_0000, 0);
    queue_word(bti_pkg::KIND_INTERP, 0, 32'hffff_ffff, 0);
    queue_word(bti_pkg::KIND_INTERP, 0, 32'h0000_0000, 0);
    queue_word(bti_pkg::KIND_INTERP, 0, 32'h0001_0000, 0);
    queue_word(bti_pkg::KIND_INTERP, 0, 32'h0002_0000, 0);
    queue_word(bti_pkg::KIND_INTERP, 0, 32'h7fff_ffff, 0);
    queue_word(bti_pkg::KIND_FLOOR, 0, 32'h8000_0000, 0);
    queue_word(bti_pkg::KIND_FLOOR, 0, 32'h0000_0000, 0);
    queue_word(bti_pkg::KIND_FLOOR, 0, 32'h7fff_ffff, 0);
    queue_word(bti_pkg::KIND_CEIL, 0, 32'h8000_0000, 0);
    queue_word(bti_pkg::KIND_CEIL, 0, 32'h0000_0000, 0);
    queue_word(bti_pkg::KIND_CEIL, 0, 32'h0002_0001, 0);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: fb = 32'h7fff_ffff;
        1: fb = 32'h8000_0000;
        2: fb = 32'h0000_0000;
        default: fb = $urandom();
      endcase
      send_idle_pct = 0;
      stall_pct = 0;
      write_reg(bti_pkg::CFG_ENTRY_COUNT, phase_count[ph]);
      write_reg(bti_pkg::CFG_FALLBACK, fb);
      case (ph % 4)
        1: send_idle_pct = 68;
        2: stall_pct = 68;
        3: begin
          send_idle_pct = 13;
          stall_pct = 13;
        end
        default: ;
      endcase
      if (ph == 3) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end

      // fill every active entry before any query can read it
      style = key_style_t'(ph % 5);
      ks.delete();
      repeat (plan_n) ks.push_back(int'($urandom()));
      case (style)
        KEYS_SPREAD, KEYS_DUPS, KEYS_EDGES: ks.sort();
        KEYS_DENSE: begin
          base = int'($urandom()) >>> 1;
          foreach (ks[i]) begin
            ks[i] = base;
            base += $urandom_range(3);
          end
        end
        default: ;
      endcase
      if (style == KEYS_DUPS) begin
        for (int i = 1; i < plan_n; i++) if ($urandom_range(2) == 0) ks[i] = ks[i-1];
      end
      if (style == KEYS_EDGES && plan_n > 1) begin
        ks[0] = 32'sh8000_0000;
        ks[plan_n-1] = 32'sh7fff_ffff;
      end
      pos_q.delete();
      for (int i = 0; i < plan_n; i++) pos_q.push_back(i);
      pos_q.shuffle();
      foreach (pos_q[j]) begin
        p = pos_q[j];
        if (style == KEYS_EDGES) v = (p % 2) ? 32'h7fff_ffff : 32'h8000_0000;
        else v = $urandom();
        queue_word(bti_pkg::KIND_LOAD, bti_pkg::POS_W'(p), ks[p], v);
      end

      if (ph == 3) begin
        // hold the output long enough that the block backs up onto its input
        hold_requests++;
        queue_random_items(33);
        wait_drained();
        queue_random_items(32);
      end else begin
        queue_random_items((plan_n == 0) ? 40 : 65);
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
